>>> rtl/grouped_bitmap_block_allocator_assert.svh
// Assertion macros for the grouped bitmap block allocator.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define BGBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define BGBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bgba_pkg.sv
// Shared types, constants and helpers for the grouped bitmap block allocator.
// No dependencies; imported by bgba_ctrl and the top-level module.
package bgba_pkg;

    // Field widths fixed by the transaction format
    localparam int BLOCK_W     = 12;
    localparam int COUNT_OUT_W = 9;
    localparam int CFG_W       = 5;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;

    // Defaults; GROUP_BLOCKS is a multiple of the bitmap word width
    localparam int NUM_GROUPS_DEF   = 16;
    localparam int GROUP_BLOCKS_DEF = 256;

    localparam logic [CFG_W-1:0] GROUPS_IN_USE_RST = CFG_W'(16);

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [BLOCK_W-1:0] block_number;
    } t_in_item;

    typedef struct packed {
        logic [BLOCK_W-1:0]     result_block;
        t_status                status;
        logic [COUNT_OUT_W-1:0] group_free_count;
    } t_out_item;

    // Finished result handed from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_res;

    // Index of the lowest clear bit of a bitmap word
    function automatic logic [BIT_W-1:0] ffz_word(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/bgba_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data (read-first). No dependencies.
module bgba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bgba_ctrl.sv
// Sequencer of the grouped bitmap block allocator: clearing pass, group and
// word scan for allocate, group lookup and update for free. Uses bgba_pkg.
module bgba_ctrl #(
    parameter int NUM_GROUPS   = bgba_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = bgba_pkg::GROUP_BLOCKS_DEF,
    parameter int WA_W         = 6,
    parameter int GA_W         = 4,
    parameter int CNT_W        = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  bgba_pkg::t_in_item            i_data,
    input  logic                          i_cfg_we,
    input  logic [bgba_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_res_ready,
    output bgba_pkg::t_res                o_res,
    output logic                          o_bmp_we,
    output logic [WA_W-1:0]               o_bmp_waddr,
    output logic [bgba_pkg::WORD_BITS-1:0] o_bmp_wdata,
    output logic [WA_W-1:0]               o_bmp_raddr,
    input  logic [bgba_pkg::WORD_BITS-1:0] i_bmp_rdata,
    output logic                          o_cnt_we,
    output logic [GA_W-1:0]               o_cnt_waddr,
    output logic [CNT_W-1:0]              o_cnt_wdata,
    output logic [GA_W-1:0]               o_cnt_raddr,
    input  logic [CNT_W-1:0]              i_cnt_rdata
);

    import bgba_pkg::*;

    localparam int WPG   = GROUP_BLOCKS / WORD_BITS;
    localparam int WORDS = NUM_GROUPS * WPG;
    localparam int WIG_W = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int G_W   = $clog2(NUM_GROUPS + 1);
    localparam int CMP_W = (G_W > CFG_W) ? G_W : CFG_W;
    localparam int REM_W = (CNT_W > BLOCK_W) ? CNT_W : BLOCK_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CNT_RD,
        S_A_CNT_CHK,
        S_A_WD_RD,
        S_A_WD_CHK,
        S_F_DIV,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_giu;
    logic [BLOCK_W-1:0] r_blk;
    logic [REM_W-1:0]   r_rem;
    logic [CMP_W-1:0]   r_g;
    logic [WA_W-1:0]    r_gbase;
    logic [WA_W-1:0]    r_waddr;
    logic [WIG_W-1:0]   r_wig;
    logic [CNT_W-1:0]   r_cnt;
    t_out_item          r_res;

    logic [CMP_W-1:0]     ng;
    logic [CMP_W-1:0]     g_next;
    logic [BIT_W-1:0]     zbit;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WA_W-1:0]      blk_word;
    logic                 word_full;
    logic                 blk_used;

    // Clamp the register to the groups that exist
    assign ng = (CMP_W'(r_giu) > CMP_W'(NUM_GROUPS)) ? CMP_W'(NUM_GROUPS) : CMP_W'(r_giu);

    assign g_next    = r_g + CMP_W'(1);
    assign zbit      = ffz_word(i_bmp_rdata);
    assign word_full = &i_bmp_rdata;
    assign blk_word  = WA_W'(r_blk >> BIT_W);
    assign blk_used  = i_bmp_rdata[r_blk[BIT_W-1:0]];
    assign bit_mask  = (r_state == S_F_CHK) ? (WORD_BITS'(1) << r_blk[BIT_W-1:0])
                                            : (WORD_BITS'(1) << zbit);

    assign o_stall = (r_state != S_IDLE);
    assign o_res   = '{valid: (r_state == S_DONE), data: r_res};

    // Drive memory ports from the current state; writes land before the next
    // item can read, so no forwarding is needed
    always_comb begin
        o_bmp_we    = 1'b0;
        o_bmp_waddr = r_waddr;
        o_bmp_wdata = '0;
        o_bmp_raddr = r_waddr;
        o_cnt_we    = 1'b0;
        o_cnt_waddr = r_g[GA_W-1:0];
        o_cnt_wdata = r_cnt - CNT_W'(1);
        o_cnt_raddr = r_g[GA_W-1:0];
        case (r_state)
            S_CLEAR: begin
                o_bmp_we    = 1'b1;
                o_cnt_we    = (32'(r_waddr) < NUM_GROUPS);
                o_cnt_waddr = r_waddr[GA_W-1:0];
                o_cnt_wdata = CNT_W'(GROUP_BLOCKS);
            end
            S_A_WD_CHK: begin
                o_bmp_we    = !word_full;
                o_bmp_wdata = i_bmp_rdata | bit_mask;
                o_cnt_we    = !word_full;
            end
            S_F_RD: begin
                o_bmp_raddr = blk_word;
            end
            S_F_CHK: begin
                o_bmp_we    = blk_used;
                o_bmp_waddr = blk_word;
                o_bmp_wdata = i_bmp_rdata & ~bit_mask;
                o_cnt_we    = blk_used;
                o_cnt_wdata = i_cnt_rdata + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_giu <= GROUPS_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_giu <= i_cfg_wdata;
        end
    end

    // Sequence each transaction through the memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_waddr <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_waddr == WA_W'(WORDS - 1)) begin
                        r_waddr <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_waddr <= r_waddr + WA_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_blk   <= i_data.block_number;
                        r_rem   <= REM_W'(i_data.block_number);
                        r_g     <= '0;
                        r_gbase <= '0;
                        if (i_data.func == FUNC_FREE) begin
                            r_state <= S_F_DIV;
                        end else if (ng == '0) begin
                            r_res   <= '{result_block: '0, status: ST_FULL,
                                         group_free_count: '0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_A_CNT_RD;
                        end
                    end
                end
                S_A_CNT_RD: begin
                    r_state <= S_A_CNT_CHK;
                end
                S_A_CNT_CHK: begin
                    r_cnt <= i_cnt_rdata;
                    if (i_cnt_rdata == '0) begin
                        // Skip a full group
                        r_g     <= g_next;
                        r_gbase <= r_gbase + WA_W'(WPG);
                        if (g_next >= ng) begin
                            r_res   <= '{result_block: '0, status: ST_FULL,
                                         group_free_count: '0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_A_CNT_RD;
                        end
                    end else begin
                        r_waddr <= r_gbase;
                        r_wig   <= '0;
                        r_state <= S_A_WD_RD;
                    end
                end
                S_A_WD_RD: begin
                    r_state <= S_A_WD_CHK;
                end
                S_A_WD_CHK: begin
                    if (!word_full) begin
                        r_res   <= '{result_block: BLOCK_W'({r_waddr, zbit}), status: ST_OK,
                                     group_free_count: COUNT_OUT_W'(r_cnt - CNT_W'(1))};
                        r_state <= S_DONE;
                    end else if (r_wig == WIG_W'(WPG - 1)) begin
                        // Group holds no clear bit: move on
                        r_g     <= g_next;
                        r_gbase <= r_gbase + WA_W'(WPG);
                        if (g_next >= ng) begin
                            r_res   <= '{result_block: '0, status: ST_FULL,
                                         group_free_count: '0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_A_CNT_RD;
                        end
                    end else begin
                        r_waddr <= r_waddr + WA_W'(1);
                        r_wig   <= r_wig + WIG_W'(1);
                        r_state <= S_A_WD_RD;
                    end
                end
                S_F_DIV: begin
                    // Find the group by repeated subtraction
                    if (r_g >= ng) begin
                        r_res   <= '{result_block: '0, status: ST_OUT_OF_RANGE,
                                     group_free_count: '0};
                        r_state <= S_DONE;
                    end else if (r_rem >= REM_W'(GROUP_BLOCKS)) begin
                        r_rem <= r_rem - REM_W'(GROUP_BLOCKS);
                        r_g   <= g_next;
                    end else begin
                        r_state <= S_F_RD;
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    if (blk_used) begin
                        r_res <= '{result_block: r_blk, status: ST_OK,
                                   group_free_count: COUNT_OUT_W'(i_cnt_rdata + CNT_W'(1))};
                    end else begin
                        r_res <= '{result_block: '0, status: ST_ALREADY_FREE,
                                   group_free_count: COUNT_OUT_W'(i_cnt_rdata)};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/grouped_bitmap_block_allocator.sv
// Grouped bitmap block allocator, top level: sequencer, bitmap and count
// memories, output register. Uses bgba_pkg, bgba_ctrl, bgba_ram.
//   Input channel i_valid / o_stall / i_data carries one transaction: an
//   allocate (func 0) or a free of block_number (func 1). Output channel
//   o_valid / i_stall / o_data returns exactly one result per transaction.
//   i_cfg_we / i_cfg_wdata set groups_in_use; write it only while idle.
//   Steps, from the accepting edge to the result in o_data:
//     allocate: a count read per group tried and a word read per word scanned,
//       bounded by one count read per group and one word read per 64 blocks;
//     free: one subtraction per group passed, then a word read and update;
//       out of range when the block lies outside the groups in use.
//   One transaction is in work at a time; the next is taken only after a
//   result reaches o_data, so the scan length sets the transaction rate.
//   After reset a clearing pass over all NUM_GROUPS * GROUP_BLOCKS / 64 words
//   (64 by default) empties the bitmap and loads every count; o_stall stays
//   high meanwhile, configuration writes are taken throughout.
//   A result waiting under i_stall sits in the output register; the next
//   transaction is accepted and worked on, and its result waits inside until
//   the register is free.
`include "grouped_bitmap_block_allocator_assert.svh"

module grouped_bitmap_block_allocator #(
    parameter int NUM_GROUPS   = bgba_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = bgba_pkg::GROUP_BLOCKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  bgba_pkg::t_in_item         i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output bgba_pkg::t_out_item        o_data,
    input  logic                       i_cfg_we,
    input  logic [bgba_pkg::CFG_W-1:0] i_cfg_wdata
);

    import bgba_pkg::*;

    localparam int WPG   = GROUP_BLOCKS / WORD_BITS;
    localparam int WORDS = NUM_GROUPS * WPG;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GA_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CNT_W = $clog2(GROUP_BLOCKS + 1);

    t_res      res;
    logic      res_ready;
    logic      r_ovalid;
    t_out_item r_odata;

    logic                 bmp_we;
    logic [WA_W-1:0]      bmp_waddr;
    logic [WORD_BITS-1:0] bmp_wdata;
    logic [WA_W-1:0]      bmp_raddr;
    logic [WORD_BITS-1:0] bmp_rdata;
    logic                 cnt_we;
    logic [GA_W-1:0]      cnt_waddr;
    logic [CNT_W-1:0]     cnt_wdata;
    logic [GA_W-1:0]      cnt_raddr;
    logic [CNT_W-1:0]     cnt_rdata;

    bgba_ctrl #(
        .NUM_GROUPS   (NUM_GROUPS),
        .GROUP_BLOCKS (GROUP_BLOCKS),
        .WA_W         (WA_W),
        .GA_W         (GA_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_bmp_we    (bmp_we),
        .o_bmp_waddr (bmp_waddr),
        .o_bmp_wdata (bmp_wdata),
        .o_bmp_raddr (bmp_raddr),
        .i_bmp_rdata (bmp_rdata),
        .o_cnt_we    (cnt_we),
        .o_cnt_waddr (cnt_waddr),
        .o_cnt_wdata (cnt_wdata),
        .o_cnt_raddr (cnt_raddr),
        .i_cnt_rdata (cnt_rdata)
    );

    // Used-block bitmap, one 64-bit word per entry
    bgba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WA_W)
    ) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (bmp_we),
        .i_waddr (bmp_waddr),
        .i_wdata (bmp_wdata),
        .i_raddr (bmp_raddr),
        .o_rdata (bmp_rdata)
    );

    // Free count per group
    bgba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_GROUPS),
        .AW    (GA_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Take a finished result when the output register is empty or draining
    assign res_ready = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_odata <= res.data;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // A result that did not fit into the output register is held
    `BGBA_ASSERT_NXT(a_res_hold, res.valid && !res_ready, res.valid && $stable(res.data), "pending result lost")
    // An accepted transaction keeps the input stalled while it is in work
    `BGBA_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input not stalled after accept")
    // Failed operations report no block
    `BGBA_ASSERT_NOW(a_fail_no_block, o_valid && (o_data.status != ST_OK), o_data.result_block == '0, "nonzero block on failure")
    // No group is touched when full or out of range
    `BGBA_ASSERT_NOW(a_untouched_count, o_valid && ((o_data.status == ST_FULL) || (o_data.status == ST_OUT_OF_RANGE)), o_data.group_free_count == '0, "count reported for untouched group")

endmodule
